FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ENTRY_W     = 26;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        KIND_INS_OK   = 2'd0,
        KIND_INS_FULL = 2'd1,
        KIND_POP      = 2'd2,
        KIND_EMPTY    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  age;
        logic [1:0]  pri;
    } entry_t;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  priority_req;
        logic [7:0]  age;
        logic [15:0] tag;
        logic [7:0]  count;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_tag;
        logic [7:0]  out_age;
        logic [1:0]  out_priority;
        logic [4:0]  occupancy;
        logic        last;
    } out_word_t;

endpackage

FILE: rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface spq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Stable priority queue kept as a circular sorted list in one RAM.
// ----------------------------------------------------------------------------
// Insert: the list is searched from the tail back to the insert point, each
// step reading one entry (S_SHIFT_RD) and writing it one slot further
// (S_SHIFT_WR); the new entry is written into the hole. Delete of N pops
// from the head: S_POP_RD, then S_POP_EMIT waits for a free output slot.
// One input word is worked on at a time; the result register frees the input.
// Reset empties the queue (count and head pointer); RAM contents are not reset.
module stable_priority_queue (
    input logic clk,
    input logic rst_n,
    spq_if.sink   in_ch,
    spq_if.source out_ch
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_POP_RD, S_POP_EMIT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] scan_reg;   // entries left to examine behind the hole
    logic [CNT_W-1:0] pops_reg;
    entry_t           new_reg;
    out_word_t        out_reg;
    logic             out_valid_reg;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           wdata, rdata;
    logic [ENTRY_W-1:0] rdata_bits;

    spq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata_bits)
    );
    assign rdata = entry_t'(rdata_bits);

    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
                                               input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(h) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    logic out_free;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE) && out_free;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    in_word_t iw;
    assign iw = in_ch.data;

    logic [8:0] del_n;
    logic       out_load;

    always_comb
    begin
        del_n = 9'(iw.count);
        if (del_n > 9'(held_reg)) del_n = 9'(held_reg);
        if (del_n > 9'(MAX_RESULTS)) del_n = 9'(MAX_RESULTS);
    end

    // A new result word is loaded into the output register.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                out_load = in_ch.valid && in_ch.ready &&
                           ((iw.opcode == OP_INSERT) ? (held_reg == CNT_W'(DEPTH))
                                                     : (del_n == '0));
            end
            S_SHIFT_RD: out_load = (scan_reg == '0);
            S_SHIFT_WR: out_load = (rdata.pri <= new_reg.pri);
            S_POP_EMIT: out_load = out_free;
            default:    out_load = 1'b0;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = slot(head_reg, scan_reg);
        wdata = new_reg;
        raddr = slot(head_reg, scan_reg - CNT_W'(1));
        unique case (state_reg)
            S_SHIFT_WR:
            begin
                if (rdata.pri > new_reg.pri)
                begin
                    we    = 1'b1;
                    wdata = rdata;
                end
            end
            S_POP_RD, S_POP_EMIT: raddr = head_reg;
            default: ;
        endcase
        // Final write of the new entry into the hole.
        if (state_reg == S_SHIFT_RD && scan_reg == '0)
        begin
            we = 1'b1;
        end
        if (state_reg == S_SHIFT_WR && rdata.pri <= new_reg.pri)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            scan_reg      <= '0;
            pops_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        new_reg <= '{tag: iw.tag, age: iw.age, pri: iw.priority_req};
                        if (iw.opcode == OP_INSERT)
                        begin
                            if (held_reg == CNT_W'(DEPTH))
                            begin
                                out_reg <= '{kind: KIND_INS_FULL, out_tag: '0,
                                             out_age: '0, out_priority: '0,
                                             occupancy: 5'(held_reg), last: 1'b1};
                            end
                            else
                            begin
                                out_reg   <= '0;
                                scan_reg  <= held_reg;
                                state_reg <= S_SHIFT_RD;
                            end
                        end
                        else
                        begin
                            if (del_n == '0)
                            begin
                                out_reg <= '{kind: KIND_EMPTY, out_tag: '0,
                                             out_age: '0, out_priority: '0,
                                             occupancy: 5'(held_reg), last: 1'b1};
                            end
                            else
                            begin
                                out_reg   <= '0;
                                pops_reg  <= CNT_W'(del_n);
                                state_reg <= S_POP_RD;
                            end
                        end
                    end
                end
                S_SHIFT_RD:
                begin
                    if (scan_reg == '0)
                    begin
                        held_reg          <= held_reg + CNT_W'(1);
                        out_reg.kind      <= KIND_INS_OK;
                        out_reg.occupancy <= 5'(held_reg + CNT_W'(1));
                        out_reg.last      <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    if (rdata.pri > new_reg.pri)
                    begin
                        scan_reg  <= scan_reg - CNT_W'(1);
                        state_reg <= S_SHIFT_RD;
                    end
                    else
                    begin
                        held_reg          <= held_reg + CNT_W'(1);
                        out_reg.kind      <= KIND_INS_OK;
                        out_reg.occupancy <= 5'(held_reg + CNT_W'(1));
                        out_reg.last      <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                S_POP_RD:
                begin
                    state_reg <= S_POP_EMIT;
                end
                S_POP_EMIT:
                begin
                    // Head read data is valid here; wait for the output slot.
                    if (out_free)
                    begin
                        out_reg.kind         <= KIND_POP;
                        out_reg.out_tag      <= rdata.tag;
                        out_reg.out_age      <= rdata.age;
                        out_reg.out_priority <= rdata.pri;
                        out_reg.occupancy    <= 5'(held_reg - CNT_W'(1));
                        out_reg.last         <= (pops_reg == CNT_W'(1));
                        held_reg             <= held_reg - CNT_W'(1);
                        head_reg             <= slot(head_reg, CNT_W'(1));
                        pops_reg             <= pops_reg - CNT_W'(1);
                        state_reg <= (pops_reg == CNT_W'(1)) ? S_IDLE : S_POP_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) held_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_RD) |-> scan_reg <= held_reg)
        else $error("insert scan beyond held entries");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> $stable(out_reg))
        else $error("result word changed while stalled");
endmodule
